@@ src/rse_pkg.sv @@
// ----------------------------------------------------------------------------
// rse_pkg
// types, codes and fixed-point helpers shared by the rpn stack evaluator
// ----------------------------------------------------------------------------
package rse_pkg;

    localparam int VW = 48;
    localparam int FB = 16;
    localparam int HW = VW / 2;
    localparam int PW = 2 * VW;
    localparam int DW = VW + FB;

    localparam logic [2:0] MODE_PUSH_INT   = 3'd0;
    localparam logic [2:0] MODE_PUSH_FLOAT = 3'd1;
    localparam logic [2:0] MODE_ADD        = 3'd2;
    localparam logic [2:0] MODE_SUB        = 3'd3;
    localparam logic [2:0] MODE_MUL        = 3'd4;
    localparam logic [2:0] MODE_DIV        = 3'd5;
    localparam logic [2:0] MODE_PRINT      = 3'd6;
    localparam logic [2:0] MODE_HALT       = 3'd7;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_HALTED    = 3'd1;
    localparam logic [2:0] STAT_UNDERFLOW = 3'd2;
    localparam logic [2:0] STAT_DIV_ZERO  = 3'd3;
    localparam logic [2:0] STAT_OVERFLOW  = 3'd4;
    localparam logic [2:0] STAT_IGNORED   = 3'd5;

    typedef enum logic [2:0] {
        OP_PUSH, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SHOW, OP_HALT
    } t_op;

    typedef struct packed {
        logic [2:0]           mode;
        logic signed [VW-1:0] operand;
        logic                 last_in_program;
    } t_in;

    typedef struct packed {
        logic                 print_valid;
        logic signed [VW-1:0] print_value;
        logic                 print_is_int;
        logic [2:0]           status;
        logic                 running;
        logic [8:0]           stack_depth;
    } t_out;

    typedef struct packed {
        t_op                  op;
        logic signed [VW-1:0] value;
        logic                 tag;
        logic                 last;
    } t_cmd;

    function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] v);
        return v[VW-1] ? VW'(-v) : VW'(v);
    endfunction

    function automatic logic signed [VW-1:0] sat_mag(input logic neg,
                                                     input logic [PW-1:0] m);
        logic [PW-1:0] lim;
        logic [VW-1:0] v;
        lim = (PW'(1) << (VW - 1)) - (neg ? PW'(0) : PW'(1));
        v = (m > lim) ? lim[VW-1:0] : m[VW-1:0];
        return neg ? VW'(-v) : VW'(v);
    endfunction

endpackage

@@ src/rse_ram.sv @@
// ----------------------------------------------------------------------------
// rse_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/rse_div.sv @@
// ----------------------------------------------------------------------------
// rse_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rse_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rse_pkg::DW-1:0]    i_dividend,
    input  logic [rse_pkg::VW-1:0]    i_divisor,
    output logic                      o_done,
    output logic [rse_pkg::DW-1:0]    o_quotient
);
    import rse_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dsr;
    logic [VW:0]   trial;
    logic          fits;

    assign trial = {r_rem, r_quo[DW-1]};
    assign fits  = trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DW);
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_dsr  <= i_divisor;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - CW'(1);
                r_rem <= fits ? VW'(trial - {1'b0, r_dsr}) : VW'(trial);
                r_quo <= {r_quo[DW-2:0], fits};
            end
        end
    end

    assign o_done     = r_busy && (r_cnt == '0);
    assign o_quotient = r_quo;

endmodule

@@ src/rse_front.sv @@
// ----------------------------------------------------------------------------
// rse_front
// accepts instructions, decodes them and queues them for execution
// ----------------------------------------------------------------------------
module rse_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  rse_pkg::t_in   i_item,
    output logic           o_valid,
    input  logic           i_pop,
    output rse_pkg::t_cmd  o_cmd
);
    import rse_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    t_cmd       cmd;
    logic [VW-1:0] trunc_m;
    logic       do_push;
    logic       do_pop;

    assign trunc_m = mag(i_item.operand) & ~VW'((64'd1 << FB) - 64'd1);

    always_comb begin
        cmd.value = i_item.operand;
        cmd.tag   = 1'b0;
        cmd.last  = i_item.last_in_program;
        unique case (i_item.mode)
            MODE_PUSH_INT: begin
                cmd.op    = OP_PUSH;
                cmd.tag   = 1'b1;
                cmd.value = i_item.operand[VW-1] ? VW'(-trunc_m) : VW'(trunc_m);
            end
            MODE_PUSH_FLOAT: cmd.op = OP_PUSH;
            MODE_ADD:        cmd.op = OP_ADD;
            MODE_SUB:        cmd.op = OP_SUB;
            MODE_MUL:        cmd.op = OP_MUL;
            MODE_DIV:        cmd.op = OP_DIV;
            MODE_PRINT:      cmd.op = OP_SHOW;
            default:         cmd.op = OP_HALT;
        endcase
    end

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_mem[r_wptr] <= cmd;
                r_wptr        <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd   = r_mem[r_rptr];

endmodule

@@ src/rse_back.sv @@
// ----------------------------------------------------------------------------
// rse_back
// executes decoded instructions on the value stack and holds the result
// ----------------------------------------------------------------------------
module rse_back #(
    parameter int STACK_DEPTH = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_pop,
    input  rse_pkg::t_cmd  i_cmd,
    output logic           o_empty,
    input  logic           i_pop,
    output rse_pkg::t_out  o_result
);
    import rse_pkg::*;

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_MUL0, S_MUL1, S_MUL2, S_DIV
    } t_state;

    t_state               r_state, n_state;
    logic [SPW-1:0]       r_sp, n_sp;
    logic                 r_run, n_run;
    logic signed [VW-1:0] r_tos, n_tos;
    logic                 r_tos_tag, n_tos_tag;
    t_op                  r_op, n_op;
    logic                 r_last, n_last;
    logic signed [VW-1:0] r_a, n_a;
    logic signed [VW-1:0] r_b, n_b;
    logic                 r_b_tag, n_b_tag;
    logic                 r_neg, n_neg;
    logic [PW-1:0]        r_acc, n_acc;
    logic                 r_out_valid, n_out_valid;
    t_out                 r_out, n_out;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [VW:0]          ram_wdata, ram_rdata;
    logic signed [VW-1:0] rd_val;
    logic [SPW-1:0]       sp_m1, sp_m2;
    logic                 fin, fin_last, f_pv, f_ptag;
    logic [2:0]           f_status;
    logic signed [VW-1:0] f_pval;
    logic                 div_start, div_done;
    logic [DW-1:0]        div_q;
    logic [VW-1:0]        ma_rd, ma_mul, mb;
    logic [HW-1:0]        mul_half;
    logic [VW+HW-1:0]     pp;
    logic signed [VW:0]   sum;
    logic [VW:0]          sum_m;

    rse_ram #(.WIDTH(VW + 1), .DEPTH(STACK_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({ma_rd, {FB{1'b0}}}),
        .i_divisor  (mb),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign rd_val   = ram_rdata[VW-1:0];
    assign sp_m1    = r_sp - SPW'(1);
    assign sp_m2    = r_sp - SPW'(2);
    assign ma_rd    = mag(rd_val);
    assign ma_mul   = mag(r_a);
    assign mb       = mag(r_b);
    assign mul_half = (r_state == S_MUL0) ? mb[HW-1:0] : mb[VW-1:HW];
    assign pp       = ma_mul * mul_half;
    assign sum      = (r_op == OP_SUB) ? ((VW+1)'(rd_val) - (VW+1)'(r_b))
                                       : ((VW+1)'(rd_val) + (VW+1)'(r_b));
    assign sum_m    = sum[VW] ? (VW+1)'(-sum) : (VW+1)'(sum);

    always_comb begin
        n_state     = r_state;
        n_sp        = r_sp;
        n_run       = r_run;
        n_tos       = r_tos;
        n_tos_tag   = r_tos_tag;
        n_op        = r_op;
        n_last      = r_last;
        n_a         = r_a;
        n_b         = r_b;
        n_b_tag     = r_b_tag;
        n_neg       = r_neg;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = sp_m1[AW-1:0];
        ram_wdata   = {r_tos_tag, r_tos};
        ram_raddr   = sp_m2[AW-1:0];
        o_pop       = 1'b0;
        div_start   = 1'b0;
        fin         = 1'b0;
        fin_last    = r_last;
        f_status    = STAT_OK;
        f_pv        = 1'b0;
        f_pval      = '0;
        f_ptag      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid && !r_out_valid) begin
                    o_pop    = 1'b1;
                    n_op     = i_cmd.op;
                    n_last   = i_cmd.last;
                    fin_last = i_cmd.last;
                    if (!r_run) begin
                        fin      = 1'b1;
                        f_status = STAT_IGNORED;
                    end else begin
                        unique case (i_cmd.op) inside
                            OP_PUSH: begin
                                fin = 1'b1;
                                if (r_sp >= SPW'(STACK_DEPTH)) begin
                                    f_status = STAT_OVERFLOW;
                                    n_run    = 1'b0;
                                end else begin
                                    ram_we    = r_sp != '0;
                                    n_tos     = i_cmd.value;
                                    n_tos_tag = i_cmd.tag;
                                    n_sp      = r_sp + SPW'(1);
                                end
                            end
                            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                                if (r_sp < SPW'(2)) begin
                                    fin      = 1'b1;
                                    f_status = STAT_UNDERFLOW;
                                    n_run    = 1'b0;
                                end else begin
                                    n_b     = r_tos;
                                    n_state = S_READ;
                                end
                            end
                            OP_SHOW: begin
                                if (r_sp == '0) begin
                                    fin      = 1'b1;
                                    f_status = STAT_UNDERFLOW;
                                    n_run    = 1'b0;
                                end else begin
                                    n_b     = r_tos;
                                    n_b_tag = r_tos_tag;
                                    n_sp    = sp_m1;
                                    if (r_sp < SPW'(2)) begin
                                        fin    = 1'b1;
                                        f_pv   = 1'b1;
                                        f_pval = r_tos;
                                        f_ptag = r_tos_tag;
                                    end else begin
                                        n_state = S_READ;
                                    end
                                end
                            end
                            default: begin
                                fin      = 1'b1;
                                f_status = STAT_HALTED;
                                n_run    = 1'b0;
                            end
                        endcase
                    end
                end
            end
            S_READ: begin
                n_a   = rd_val;
                n_neg = rd_val[VW-1] ^ r_b[VW-1];
                case (r_op) inside
                    OP_SHOW: begin
                        n_tos     = rd_val;
                        n_tos_tag = ram_rdata[VW];
                        fin       = 1'b1;
                        f_pv      = 1'b1;
                        f_pval    = r_b;
                        f_ptag    = r_b_tag;
                        n_state   = S_IDLE;
                    end
                    OP_ADD, OP_SUB: begin
                        n_tos     = sat_mag(sum[VW], PW'(sum_m));
                        n_tos_tag = 1'b0;
                        n_sp      = sp_m1;
                        fin       = 1'b1;
                        n_state   = S_IDLE;
                    end
                    OP_MUL: begin
                        n_state = S_MUL0;
                    end
                    default: begin
                        if (r_b == '0) begin
                            n_tos     = '0;
                            n_tos_tag = 1'b0;
                            n_sp      = sp_m1;
                            n_run     = 1'b0;
                            f_status  = STAT_DIV_ZERO;
                            fin       = 1'b1;
                            n_state   = S_IDLE;
                        end else begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                    end
                endcase
            end
            S_MUL0: begin
                n_acc   = PW'(pp);
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_acc   = r_acc + (PW'(pp) << HW);
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_tos     = sat_mag(r_neg, r_acc >> FB);
                n_tos_tag = 1'b0;
                n_sp      = sp_m1;
                fin       = 1'b1;
                n_state   = S_IDLE;
            end
            S_DIV: begin
                if (div_done) begin
                    n_tos     = sat_mag(r_neg, PW'(div_q));
                    n_tos_tag = 1'b0;
                    n_sp      = sp_m1;
                    fin       = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (fin) begin
            n_out_valid       = 1'b1;
            n_out.print_valid = f_pv;
            n_out.print_value = f_pval;
            n_out.print_is_int = f_ptag;
            n_out.status      = f_status;
            n_out.running     = n_run;
            n_out.stack_depth = 9'(n_sp);
            if (fin_last) begin
                n_sp  = '0;
                n_run = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_run       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_run       <= n_run;
            r_out_valid <= n_out_valid;
        end
        r_tos     <= n_tos;
        r_tos_tag <= n_tos_tag;
        r_op      <= n_op;
        r_last    <= n_last;
        r_a       <= n_a;
        r_b       <= n_b;
        r_b_tag   <= n_b_tag;
        r_neg     <= n_neg;
        r_acc     <= n_acc;
        r_out     <= n_out;
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result lost");

    a_busy_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_run && r_sp >= SPW'(1)))
        else $error("execution while stopped or empty");

endmodule

@@ src/rpn_stack_evaluator.sv @@
// execution: push, halt and stopped items finish when accepted; add/sub/print
//   read the second stack entry first (print of the only value finishes when accepted),
//   mul then steps through S_MUL0, S_MUL1 and S_MUL2, div waits on the one-bit-per-cycle divider
// throughput: one instruction at a time, a new one is accepted only once the previous
//   result transaction is taken; the stack ram read port is shared by all pops
// reset: synchronous active low, empties both queues, stack empty, running
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// stack machine evaluating rpn instructions on tagged fixed-point values
// ----------------------------------------------------------------------------
module rpn_stack_evaluator #(
    parameter int STACK_DEPTH = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  rse_pkg::t_in  i_item,
    output logic          o_empty,
    input  logic          i_pop,
    output rse_pkg::t_out o_result
);
    import rse_pkg::*;

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;

    rse_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .o_full  (o_full),
        .i_item  (i_item),
        .o_valid (cmd_valid),
        .i_pop   (cmd_pop),
        .o_cmd   (cmd)
    );

    rse_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (cmd_valid),
        .o_pop    (cmd_pop),
        .i_cmd    (cmd),
        .o_empty  (o_empty),
        .i_pop    (i_pop),
        .o_result (o_result)
    );

endmodule
